### hw/rtl/sfx_pkg.sv
// ----------------------------------------------------------------------------
// sfx_pkg
// Shared types, codes and helpers for the sentence framer.
// ----------------------------------------------------------------------------
`default_nettype none

package sfx_pkg;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DOLLAR,
    PH_BODY,
    PH_CR
  } phase_e;

  localparam logic [1:0] ST_GOOD     = 2'd0;
  localparam logic [1:0] ST_NO_CSUM  = 2'd1;
  localparam logic [1:0] ST_MISMATCH = 2'd2;
  localparam logic [1:0] ST_TOO_LONG = 2'd3;

  localparam logic [1:0] LK_S = 2'd0;
  localparam logic [1:0] LK_C = 2'd1;
  localparam logic [1:0] LK_B = 2'd2;

  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_S       = 8'h53;
  localparam logic [7:0] CH_C       = 8'h43;
  localparam logic [7:0] CH_B       = 8'h42;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;

  localparam int unsigned MinTrailerLen = 7;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] length;
    logic [1:0] kind;
  } result_t;

  function automatic logic [7:0] upcase(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

  function automatic logic [7:0] hexdigit(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = 8'h30 + {4'b0, v};
    end else begin
      r = 8'h37 + {4'b0, v};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/sfx_core.sv
// ----------------------------------------------------------------------------
// sfx_core
// Framing state machine, trailer window, running XOR and length counter.
// ----------------------------------------------------------------------------
`default_nettype none

module sfx_core #(
  parameter int unsigned MAX_LEN = 128
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            accept_i,
  input  wire logic [7:0]      data_byte_i,
  output logic                 res_valid_o,
  output sfx_pkg::result_t     res_o
);

  localparam int unsigned CW = $clog2(MAX_LEN + 1);

  sfx_pkg::phase_e phase_q, phase_d;
  logic [7:0]      xor_q, xor_d;
  logic [7:0]      win_q [4];
  logic [7:0]      win_d [4];
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [1:0]      kind_q, kind_d;

  logic [7:0]      c;
  logic            is_leader, printable;
  logic [CW-1:0]   cnt_inc;
  logic [CW+7:0]   cnt_ext;
  logic            csum_ok;
  logic [1:0]      fin_status;

  assign c         = data_byte_i;
  assign is_leader = (c == sfx_pkg::CH_S) || (c == sfx_pkg::CH_C) || (c == sfx_pkg::CH_B);
  assign printable = (c >= 8'h20) && (c <= 8'h7E);
  assign cnt_inc   = (cnt_q < CW'(MAX_LEN)) ? cnt_q + CW'(1) : cnt_q;
  assign cnt_ext   = {8'b0, cnt_inc};

  assign csum_ok = (sfx_pkg::upcase(win_q[2]) == sfx_pkg::hexdigit(xor_q[7:4])) &&
                   (sfx_pkg::upcase(win_q[1]) == sfx_pkg::hexdigit(xor_q[3:0]));

  always_comb begin
    if (cnt_inc >= CW'(sfx_pkg::MinTrailerLen) && win_q[3] == sfx_pkg::CH_PERCENT) begin
      fin_status = csum_ok ? sfx_pkg::ST_GOOD : sfx_pkg::ST_MISMATCH;
    end else begin
      fin_status = sfx_pkg::ST_NO_CSUM;
    end
    if (fin_status != sfx_pkg::ST_MISMATCH && cnt_inc >= CW'(MAX_LEN)) begin
      fin_status = sfx_pkg::ST_TOO_LONG;
    end
  end

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (accept_i) begin
      case (phase_q)
        sfx_pkg::PH_IDLE: begin
          if (c == sfx_pkg::CH_DOLLAR) phase_d = sfx_pkg::PH_DOLLAR;
        end
        sfx_pkg::PH_DOLLAR: begin
          phase_d = is_leader ? sfx_pkg::PH_BODY : sfx_pkg::PH_IDLE;
        end
        sfx_pkg::PH_BODY: begin
          if (c == sfx_pkg::CH_CR) begin
            phase_d = sfx_pkg::PH_CR;
          end else if (c == sfx_pkg::CH_LF) begin
            phase_d = sfx_pkg::PH_IDLE;
          end else if (c == sfx_pkg::CH_DOLLAR) begin
            phase_d = sfx_pkg::PH_DOLLAR;
          end else if (!printable) begin
            phase_d = sfx_pkg::PH_IDLE;
          end
        end
        sfx_pkg::PH_CR: begin
          phase_d = sfx_pkg::PH_IDLE;
        end
        default: phase_d = sfx_pkg::PH_IDLE;
      endcase
    end
  end

  // datapath and result
  always_comb begin
    logic push, restart;
    push        = 1'b0;
    restart     = 1'b0;
    xor_d       = xor_q;
    win_d       = win_q;
    cnt_d       = cnt_q;
    kind_d      = kind_q;
    res_valid_o = 1'b0;
    res_o.status = fin_status;
    res_o.length = cnt_ext[7:0];
    res_o.kind   = kind_q;
    if (accept_i) begin
      case (phase_q)
        sfx_pkg::PH_IDLE: begin
          restart = (c == sfx_pkg::CH_DOLLAR);
        end
        sfx_pkg::PH_DOLLAR: begin
          if (is_leader) begin
            push = 1'b1;
            if (c == sfx_pkg::CH_S) begin
              kind_d = sfx_pkg::LK_S;
            end else if (c == sfx_pkg::CH_C) begin
              kind_d = sfx_pkg::LK_C;
            end else begin
              kind_d = sfx_pkg::LK_B;
            end
          end
        end
        sfx_pkg::PH_BODY: begin
          if (c == sfx_pkg::CH_CR) begin
            push = 1'b1;
          end else if (c == sfx_pkg::CH_LF) begin
            res_valid_o = 1'b1;
            cnt_d       = cnt_inc;
          end else if (c == sfx_pkg::CH_DOLLAR) begin
            restart = 1'b1;
          end else if (printable) begin
            push = 1'b1;
          end
        end
        sfx_pkg::PH_CR: begin
          if (c == sfx_pkg::CH_LF) begin
            res_valid_o = 1'b1;
            cnt_d       = cnt_inc;
          end
        end
        default: ;
      endcase
    end
    if (restart) begin
      xor_d = 8'h00;
      for (int i = 0; i < 4; i++) win_d[i] = 8'h00;
      cnt_d = CW'(1);
    end else if (push) begin
      xor_d    = xor_q ^ win_q[3];
      win_d[3] = win_q[2];
      win_d[2] = win_q[1];
      win_d[1] = win_q[0];
      win_d[0] = c;
      cnt_d    = cnt_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sfx_pkg::PH_IDLE;
      xor_q   <= 8'h00;
      for (int i = 0; i < 4; i++) win_q[i] <= 8'h00;
      cnt_q   <= '0;
      kind_q  <= 2'd0;
    end else begin
      phase_q <= phase_d;
      xor_q   <= xor_d;
      win_q   <= win_d;
      cnt_q   <= cnt_d;
      kind_q  <= kind_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/sfx_outbuf.sv
// ----------------------------------------------------------------------------
// sfx_outbuf
// Two-entry result buffer between the framer and the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module sfx_outbuf (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire sfx_pkg::result_t push_data_i,
  output logic                  full_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output sfx_pkg::result_t      out_data_o
);

  sfx_pkg::result_t mem_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;
  logic             pop;

  assign full_o      = (cnt_q == 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = mem_q[rd_q];
  assign pop         = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      case ({push_i, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/sentence_framer_xor_check.sv
// ----------------------------------------------------------------------------
// sentence_framer_xor_check
// Frames '$'-led ASCII sentences and checks the optional '%' hex XOR trailer.
// ----------------------------------------------------------------------------
// One byte beat is taken every cycle while in_stall_o is low. The framer
// state machine updates on each accepted byte and a completed sentence (its
// LF beat) writes one result into a two-entry output buffer, which registers
// it before it appears on the output. Input stall rises only while both
// buffer entries wait on the output side. Results give status, length from
// '$' through LF (saturating at MAX_LEN, low 8 bits) and leader kind.
`default_nettype none

module sentence_framer_xor_check #(
  parameter int unsigned MAX_LEN = 128
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] data_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [1:0]      frame_status_o,
  output logic [7:0]      frame_length_o,
  output logic [1:0]      leader_kind_o
);

  logic             full, accept, res_valid;
  sfx_pkg::result_t res, out_data;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  sfx_core #(
    .MAX_LEN (MAX_LEN)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  sfx_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign frame_status_o = out_data.status;
  assign frame_length_o = out_data.length;
  assign leader_kind_o  = out_data.kind;

endmodule

`default_nettype wire
